[rtl/tlsnb_pkg.sv]
// ----------------------------------------------------------------------------
// tlsnb_pkg: shared types and constants of the traffic light sequencer
// Register indexes, lamp codes, phase codes and the queue entry format.
// ----------------------------------------------------------------------------
package tlsnb_pkg;

  localparam int SampleW  = 12;
  localparam int SecondsW = 7;
  localparam int HalfW    = 8;
  localparam int CountW   = 7;
  localparam int CfgIdxW  = 2;
  localparam int CfgDataW = 12;
  localparam int TdataW   = 16;

  // Register indexes
  localparam logic [CfgIdxW-1:0] REG_THRESHOLD = 2'd0;
  localparam logic [CfgIdxW-1:0] REG_GREEN     = 2'd1;
  localparam logic [CfgIdxW-1:0] REG_YELLOW    = 2'd2;
  localparam logic [CfgIdxW-1:0] REG_RED       = 2'd3;

  // Register reset values
  localparam logic [SampleW-1:0]  THRESHOLD_RST = 12'd2000;
  localparam logic [SecondsW-1:0] GREEN_RST     = 7'd7;
  localparam logic [SecondsW-1:0] YELLOW_RST    = 7'd3;
  localparam logic [SecondsW-1:0] RED_RST       = 7'd5;

  // Phase codes
  localparam logic [1:0] PH_GREEN  = 2'd0;
  localparam logic [1:0] PH_YELLOW = 2'd1;
  localparam logic [1:0] PH_RED    = 2'd2;

  // Lamp register bits: {red, yellow, green}
  localparam logic [2:0] LAMP_GREEN  = 3'b001;
  localparam logic [2:0] LAMP_YELLOW = 3'b010;
  localparam logic [2:0] LAMP_RED    = 3'b100;
  localparam logic [2:0] LAMP_OFF    = 3'b000;

  localparam logic [SecondsW-1:0] SEC_MIN   = 7'd1;
  localparam logic [SecondsW-1:0] SEC_MAX   = 7'd99;
  localparam logic [CountW-1:0]   NIGHT_MAX = 7'd99;
  localparam logic [CountW-1:0]   NIGHT_RST = 7'd1;

  typedef struct packed {
    logic [SampleW-1:0]  threshold;
    logic [SecondsW-1:0] green;
    logic [SecondsW-1:0] yellow;
    logic [SecondsW-1:0] red;
  } cfg_t;

  // Classified tick, handed from the front to the back
  typedef struct packed {
    logic night;
    logic button;
  } tick_t;

  typedef struct packed {
    logic              night_mode;
    logic              display_clear;
    logic [CountW-1:0] show_value;
    logic              show_valid;
    logic              indicator_blue;
    logic              lamp_green;
    logic              lamp_yellow;
    logic              lamp_red;
  } result_t;

  // Seconds of a phase, clamped to 1..99; the unused code acts as red
  function automatic logic [SecondsW-1:0] phase_secs(input logic [1:0] ph, input cfg_t c);
    logic [SecondsW-1:0] s;
    unique case (ph)
      PH_GREEN:  s = c.green;
      PH_YELLOW: s = c.yellow;
      default:   s = c.red;
    endcase
    if (s < SEC_MIN) s = SEC_MIN;
    if (s > SEC_MAX) s = SEC_MAX;
    return s;
  endfunction

  function automatic logic [2:0] phase_lamp(input logic [1:0] ph);
    logic [2:0] l;
    unique case (ph)
      PH_GREEN:  l = LAMP_GREEN;
      PH_YELLOW: l = LAMP_YELLOW;
      default:   l = LAMP_RED;
    endcase
    return l;
  endfunction

endpackage

[rtl/tlsnb_front.sv]
// ----------------------------------------------------------------------------
// tlsnb_front: tick intake
// Accepts ticks, classifies day or night against the threshold, holds one.
// ----------------------------------------------------------------------------
module tlsnb_front (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_tvalid,
  output logic                         in_tready,
  input  logic [tlsnb_pkg::SampleW-1:0] light_sample,
  input  logic                         button_level,
  input  logic [tlsnb_pkg::SampleW-1:0] threshold,
  output logic                         push_valid,
  input  logic                         push_ready,
  output tlsnb_pkg::tick_t             push_tick
);
  import tlsnb_pkg::*;

  logic  valid_r;
  tick_t tick_r;

  assign in_tready  = !valid_r || push_ready;
  assign push_valid = valid_r;
  assign push_tick  = tick_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_tready) begin
      valid_r <= in_tvalid;
    end
  end

  // Classify on intake; threshold only changes while idle if the user keeps to that, not enforced here
  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      tick_r.night  <= (light_sample > threshold);
      tick_r.button <= button_level;
    end
  end

endmodule

[rtl/tlsnb_queue.sv]
// ----------------------------------------------------------------------------
// tlsnb_queue: tick queue
// Short first-in first-out buffer between the front and the back.
// ----------------------------------------------------------------------------
module tlsnb_queue #(
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push_valid,
  output logic             push_ready,
  input  tlsnb_pkg::tick_t push_tick,
  output logic             pop_valid,
  input  logic             pop_ready,
  output tlsnb_pkg::tick_t pop_tick
);
  import tlsnb_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL = CW'(DEPTH);

  tick_t         mem_r [DEPTH];
  logic [AW-1:0] wr_ptr_r, rd_ptr_r;
  logic [CW-1:0] count_r;
  logic          do_push, do_pop;

  assign push_ready = (count_r != FULL);
  assign pop_valid  = (count_r != '0);
  assign pop_tick   = mem_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_tick;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) wr_ptr_r <= (wr_ptr_r == LAST) ? '0 : wr_ptr_r + AW'(1);
      if (do_pop)  rd_ptr_r <= (rd_ptr_r == LAST) ? '0 : rd_ptr_r + AW'(1);
      if (do_push && !do_pop)      count_r <= count_r + CW'(1);
      else if (do_pop && !do_push) count_r <= count_r - CW'(1);
    end
  end

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= FULL)
    else $error("queue count beyond depth");

  a_push_grows: assert property (@(posedge clk) disable iff (!rst_n)
    (do_push && !do_pop) |=> (count_r == $past(count_r) + CW'(1)))
    else $error("queue count did not grow on push");

  a_pop_shrinks: assert property (@(posedge clk) disable iff (!rst_n)
    (do_pop && !do_push) |=> (count_r == $past(count_r) - CW'(1)))
    else $error("queue count did not shrink on pop");

endmodule

[rtl/tlsnb_back.sv]
// ----------------------------------------------------------------------------
// tlsnb_back: sequencer
// Runs the day phases, the night blink and the button logic, one tick per pop.
// ----------------------------------------------------------------------------
module tlsnb_back (
  input  logic               clk,
  input  logic               rst_n,
  input  tlsnb_pkg::cfg_t    cfg,
  input  logic               pop_valid,
  output logic               pop_ready,
  input  tlsnb_pkg::tick_t   pop_tick,
  output logic               res_valid,
  input  logic               res_ready,
  output tlsnb_pkg::result_t res
);
  import tlsnb_pkg::*;

  logic [1:0]        phase_r,  phase_nxt;
  logic [HalfW-1:0]  half_r,   half_nxt;
  logic              dblink_r, dblink_nxt;
  logic [CountW-1:0] dcount_r, dcount_nxt;
  logic              nblink_r, nblink_nxt;
  logic [CountW-1:0] ncount_r, ncount_nxt;
  logic              en_r,     en_nxt;
  logic [2:0]        lamp_r,   lamp_nxt;
  logic              blue_r,   blue_nxt;
  logic              valid_r;
  result_t           res_r,    res_nxt;

  logic              pop;
  logic [SecondsW-1:0] secs, secs_next;
  logic [2:0]        bit_now;
  logic [HalfW-1:0]  half_dec;
  logic [1:0]        phase_adv;
  logic              show_v, clr;
  logic [CountW-1:0] show_d;

  assign pop_ready = !valid_r || res_ready;
  assign pop       = pop_valid && pop_ready;
  assign res_valid = valid_r;
  assign res       = res_r;

  always_comb begin
    phase_nxt  = phase_r;
    half_nxt   = half_r;
    dblink_nxt = dblink_r;
    dcount_nxt = dcount_r;
    nblink_nxt = nblink_r;
    ncount_nxt = ncount_r;
    en_nxt     = en_r;
    lamp_nxt   = lamp_r;
    blue_nxt   = blue_r;
    show_v     = 1'b0;
    show_d     = '0;
    clr        = 1'b0;
    secs       = phase_secs(phase_r, cfg);
    bit_now    = phase_lamp(phase_r);
    half_dec   = (half_r != '0) ? half_r - HalfW'(1) : half_r;
    phase_adv  = (phase_r >= PH_RED) ? PH_GREEN : phase_r + 2'd1;
    secs_next  = phase_secs(phase_adv, cfg);

    // Button edge: follow the level, light or darken blue, clear the display on release
    if (pop_tick.button != en_r) begin
      en_nxt   = pop_tick.button;
      blue_nxt = pop_tick.button;
      clr      = !pop_tick.button;
    end

    if (pop_tick.night) begin
      nblink_nxt = !nblink_r;
      lamp_nxt   = nblink_nxt ? LAMP_YELLOW : LAMP_OFF;
      if (nblink_nxt) begin
        if (en_nxt) begin
          show_v = 1'b1;
          show_d = ncount_r;
        end
        ncount_nxt = (ncount_r >= NIGHT_MAX) ? NIGHT_RST : ncount_r + CountW'(1);
      end
    end else begin
      if (half_r == {secs, 1'b0}) begin
        dcount_nxt = secs - SecondsW'(1);
        dblink_nxt = 1'b1;
        lamp_nxt   = bit_now;
      end else begin
        dblink_nxt = !dblink_r;
        lamp_nxt   = dblink_nxt ? (lamp_r | bit_now) : (lamp_r & ~bit_now);
      end
      if (dblink_nxt && en_nxt) begin
        show_v = 1'b1;
        show_d = dcount_nxt;
        if (dcount_nxt != '0) dcount_nxt = dcount_nxt - CountW'(1);
      end
      half_nxt = half_dec;
      if (half_dec == '0) begin
        phase_nxt = phase_adv;
        half_nxt  = {secs_next, 1'b0};
      end
    end

    res_nxt.lamp_red       = lamp_nxt[2];
    res_nxt.lamp_yellow    = lamp_nxt[1];
    res_nxt.lamp_green     = lamp_nxt[0];
    res_nxt.indicator_blue = blue_nxt;
    res_nxt.show_valid     = show_v;
    res_nxt.show_value     = show_d;
    res_nxt.display_clear  = clr;
    res_nxt.night_mode     = pop_tick.night;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_GREEN;
      half_r   <= {GREEN_RST, 1'b0};
      dblink_r <= 1'b0;
      dcount_r <= '0;
      nblink_r <= 1'b0;
      ncount_r <= NIGHT_RST;
      en_r     <= 1'b0;
      lamp_r   <= LAMP_OFF;
      blue_r   <= 1'b0;
      valid_r  <= 1'b0;
    end else begin
      if (pop) begin
        phase_r  <= phase_nxt;
        half_r   <= half_nxt;
        dblink_r <= dblink_nxt;
        dcount_r <= dcount_nxt;
        nblink_r <= nblink_nxt;
        ncount_r <= ncount_nxt;
        en_r     <= en_nxt;
        lamp_r   <= lamp_nxt;
        blue_r   <= blue_nxt;
      end
      if (pop_ready) valid_r <= pop_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) res_r <= res_nxt;
  end

  a_pop_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    pop |=> valid_r)
    else $error("popped tick produced no result");

  a_night_lamps: assert property (@(posedge clk) disable iff (!rst_n)
    (valid_r && res_r.night_mode) |-> (!res_r.lamp_red && !res_r.lamp_green))
    else $error("red or green lit in night mode");

  a_phase_legal: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r != 2'd3)
    else $error("unused phase code reached");

  a_blue_tracks_enable: assert property (@(posedge clk) disable iff (!rst_n)
    blue_r == en_r)
    else $error("indicator out of step with display enable");

endmodule

[rtl/traffic_light_sequencer_with_night_blink_core.sv]
// ----------------------------------------------------------------------------
// traffic_light_sequencer_with_night_blink_core: traffic light sequencer
// Day cycle green, yellow, red with blinking phase lamp and countdown; night
// yellow blink with a wrapping counter; button-driven display enable.
// ----------------------------------------------------------------------------
//
//  channel | dir | handshake               | payload
//  --------+-----+-------------------------+--------------------------------------
//  in_     | in  | in_tvalid / in_tready   | in_tdata: light_sample, button_level
//  out_    | out | out_tvalid / out_tready | out_tdata: lamps, blue, show, clear, night
//  cfg_    | in  | cfg_we                  | cfg_index, cfg_wdata
//
//  One tick per clock is accepted and one result per clock is delivered
//  while out_tready stays high; a result is offered once its tick has
//  passed the front register, then the queue, then the result register
//  in the sequencer. The sequencer updates its state once per popped tick,
//  which sets the rate. Reset is synchronous: it restores the register
//  defaults and the phase state, with no clearing pass. Each side stalls on
//  its own: the queue absorbs ticks while the result waits to be taken.
//
module traffic_light_sequencer_with_night_blink_core #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // [11:0] light_sample, [12] button_level, [15:13] zero
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // [0] lamp_red, [1] lamp_yellow, [2] lamp_green,
                                  // [3] indicator_blue, [4] show_valid,
                                  // [11:5] show_value, [12] display_clear,
                                  // [13] night_mode, [15:14] zero
  input  logic                            cfg_we,
  input  logic [tlsnb_pkg::CfgIdxW-1:0]   cfg_index,
  input  logic [tlsnb_pkg::CfgDataW-1:0]  cfg_wdata
);
  import tlsnb_pkg::*;

  cfg_t    cfg_r;
  logic    push_valid, push_ready, pop_valid, pop_ready;
  tick_t   push_tick, pop_tick;
  result_t res;

  // Register file: write only; writes are taken while idle only if the user keeps to that, not enforced here
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.threshold <= THRESHOLD_RST;
      cfg_r.green     <= GREEN_RST;
      cfg_r.yellow    <= YELLOW_RST;
      cfg_r.red       <= RED_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_THRESHOLD: cfg_r.threshold <= cfg_wdata;
        REG_GREEN:     cfg_r.green     <= cfg_wdata[SecondsW-1:0];
        REG_YELLOW:    cfg_r.yellow    <= cfg_wdata[SecondsW-1:0];
        REG_RED:       cfg_r.red       <= cfg_wdata[SecondsW-1:0];
        default:       cfg_r           <= cfg_r;
      endcase
    end
  end

  // Classify each tick on intake
  tlsnb_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_tvalid    (in_tvalid),
    .in_tready    (in_tready),
    .light_sample (in_tdata[SampleW-1:0]),
    .button_level (in_tdata[SampleW]),
    .threshold    (cfg_r.threshold),
    .push_valid   (push_valid),
    .push_ready   (push_ready),
    .push_tick    (push_tick)
  );

  // Buffer classified ticks so front and sequencer stall independently
  tlsnb_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_tick  (push_tick),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_tick   (pop_tick)
  );

  // Advance the light state one tick per pop, hold the result until taken
  tlsnb_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_tick  (pop_tick),
    .res_valid (out_tvalid),
    .res_ready (out_tready),
    .res       (res)
  );

  // Pack the result, zero fill to the byte boundary
  assign out_tdata = {2'b00, res.night_mode, res.display_clear, res.show_value,
                      res.show_valid, res.indicator_blue, res.lamp_green,
                      res.lamp_yellow, res.lamp_red};

endmodule
